@@ sv/tsnc_pkg.sv @@
// shared constants and helper functions for the texture sampler
package tsnc_pkg;

  localparam int TEXEL_BYTES   = 65536;
  localparam int ADDR_W        = $clog2(TEXEL_BYTES);
  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W         = 13;
  localparam int UNIT_W        = 17;
  localparam int CFG_IDX_W     = 3;

  localparam logic [31:0]       Q_ONE    = 32'h0001_0000;
  localparam logic [UNIT_W-1:0] UNIT_ONE = 17'h1_0000;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [1:0] MODE_CHECKER = 2'd0;
  localparam logic [1:0] MODE_UV      = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECKER_SCALE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_CHANNELS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEXEL_SCALE    = 3'd5;

  // zero acts as one, large sizes saturate
  function automatic logic [DIM_W-1:0] fix_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = d;
    end
    return r;
  endfunction

  // signed q16.16 clamped to [0,1]
  function automatic logic [UNIT_W-1:0] clamp_unit(input logic [31:0] x);
    logic [UNIT_W-1:0] r;
    if (x[31]) begin
      r = '0;
    end else if (x > Q_ONE) begin
      r = UNIT_ONE;
    end else begin
      r = x[UNIT_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/tsnc_ram.sv @@
// generic single-port synchronous ram with registered read
module tsnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/texture_sampler_nearest_checker_uv_top.sv @@
// texture sampler top level: checkerboard, uv and nearest image modes
//
// requests arrive on in_valid/in_ready. a write request (req_type 0) stores
// texel_byte at texel_addr in the 64 KiB texel ram and returns nothing;
// writes can follow back to back. a sample request (req_type 1) returns one
// rgba result on out_valid/out_ready, by mode.
// steps before S_FIN loads the result into the output register: uv mode
//   S_MUL1; checkerboard mode S_MUL1 and S_MUL2 (one shared 32x32 multiplier,
//   u then v); image mode, where C is the channel count (0 to 4): S_MUL1 and
//   S_MUL2 index multiplies, S_ADDR, then, unless C is 0, S_READ, one byte a
//   cycle from the single-port texel ram, and S_DRAIN for the last read data.
// in_ready is high only while no request is in flight, so a new request is
// taken the cycle after the previous one finishes; a sample holds the input
// until it leaves S_FIN.
// the output register holds a finished result while the receiver stalls; the
// next request may still be accepted and worked on, and it waits in its last
// step until the output register is free.
// configuration is written through cfg_write/cfg_index/cfg_data while idle.
// synchronous reset clears the control state and restores register defaults;
// the texel ram is not cleared and must be written before it is sampled.
module texture_sampler_nearest_checker_uv_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               req_type,
  input  logic [15:0]                        texel_addr,
  input  logic [7:0]                         texel_byte,
  input  logic signed [31:0]                 coord_u,
  input  logic signed [31:0]                 coord_v,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 out_red,
  output logic signed [31:0]                 out_green,
  output logic signed [31:0]                 out_blue,
  output logic signed [31:0]                 out_alpha,
  input  logic                               cfg_write,
  input  logic [tsnc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);
  import tsnc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_ADDR, S_READ, S_DRAIN, S_FIN
  } state_t;

  state_t state;

  logic [1:0]       mode;
  logic [31:0]      checker_scale;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [2:0]       image_channels;
  logic [15:0]      texel_scale;

  logic [31:0] u_r;
  logic [31:0] v_r;
  logic        pu_r;
  logic [11:0] i_r;
  logic [11:0] j_r;
  logic [15:0] lin_r;
  logic [15:0] base_r;
  logic [1:0]  k;
  logic        cap_valid;
  logic [1:0]  cap_idx;
  logic [31:0] res [4];

  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [2:0]        ch_eff;
  logic [UNIT_W-1:0] u_cl;
  logic [UNIT_W-1:0] v_fl;
  logic [29:0]       iu_prod;
  logic [29:0]       jv_prod;
  logic [11:0]       i_next;
  logic [11:0]       j_next;
  logic [24:0]       jw_prod;
  logic [15:0]       lin_next;
  logic [18:0]       lc_prod;
  logic [31:0]       mul_a;
  logic [63:0]       chk_prod;
  logic              chk_bit;
  logic [31:0]       chk_color;
  logic [23:0]       tex_prod;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_CHECKER;
      checker_scale  <= 32'd655360;
      image_width    <= DIM_W'(1);
      image_height   <= DIM_W'(1);
      image_channels <= 3'd4;
      texel_scale    <= 16'd257;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:           mode           <= cfg_data[1:0];
        REG_CHECKER_SCALE:  checker_scale  <= cfg_data;
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[DIM_W-1:0];
        REG_IMAGE_CHANNELS: image_channels <= cfg_data[2:0];
        REG_TEXEL_SCALE:    texel_scale    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // image index path
  assign w_eff   = fix_dim(image_width);
  assign h_eff   = fix_dim(image_height);
  assign ch_eff  = (image_channels > 3'd4) ? 3'd4 : image_channels;
  assign u_cl    = clamp_unit(u_r);
  assign v_fl    = UNIT_ONE - clamp_unit(v_r);
  assign iu_prod = 30'(u_cl) * 30'(w_eff);
  assign jv_prod = 30'(v_fl) * 30'(h_eff);
  assign i_next  = (iu_prod[28:16] >= w_eff) ? 12'(w_eff - DIM_W'(1)) : iu_prod[27:16];
  assign j_next  = (jv_prod[28:16] >= h_eff) ? 12'(h_eff - DIM_W'(1)) : jv_prod[27:16];
  assign jw_prod  = 25'(j_r) * 25'(w_eff);
  assign lin_next = jw_prod[15:0] + 16'(i_r);
  assign lc_prod  = 19'(lin_r) * 19'(ch_eff);

  // checkerboard parity: bit 32 of the signed-by-unsigned product
  assign mul_a     = (state == S_MUL2) ? v_r : u_r;
  assign chk_prod  = 64'(mul_a) * 64'(checker_scale);
  assign chk_bit   = chk_prod[32] ^ (mul_a[31] & checker_scale[0]);
  assign chk_color = (chk_bit == pu_r) ? 32'd0 : Q_ONE;

  assign tex_prod = 24'(ram_rdata) * 24'(texel_scale);

  assign in_ready = (state == S_IDLE);
  assign ram_we   = in_valid && (state == S_IDLE) && (req_type == REQ_WRITE);
  assign ram_addr = (state == S_IDLE) ? texel_addr[ADDR_W-1:0]
                                      : ADDR_W'(base_r + 16'(k));

  tsnc_ram #(
    .WIDTH (8),
    .DEPTH (TEXEL_BYTES)
  ) u_texel_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (texel_byte),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cap_valid <= 1'b0;
      k         <= 2'd0;
    end else begin
      cap_valid <= (state == S_READ);
      cap_idx   <= k;
      if (cap_valid) begin
        res[cap_idx] <= {8'd0, tex_prod};
      end
      if (state == S_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            u_r <= coord_u;
            v_r <= coord_v;
            if (req_type == REQ_SAMPLE) begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          priority if (mode == MODE_CHECKER) begin
            pu_r  <= chk_bit;
            state <= S_MUL2;
          end else if (mode == MODE_UV) begin
            res[0] <= u_r;
            res[1] <= v_r;
            res[2] <= 32'd0;
            res[3] <= Q_ONE;
            state  <= S_FIN;
          end else begin
            i_r   <= i_next;
            j_r   <= j_next;
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (mode == MODE_CHECKER) begin
            res[0] <= chk_color;
            res[1] <= chk_color;
            res[2] <= chk_color;
            res[3] <= Q_ONE;
            state  <= S_FIN;
          end else begin
            lin_r <= lin_next;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          base_r <= lc_prod[15:0];
          k      <= 2'd0;
          res[0] <= 32'd0;
          res[1] <= 32'd0;
          res[2] <= 32'd0;
          res[3] <= Q_ONE;
          state  <= (ch_eff == 3'd0) ? S_FIN : S_READ;
        end
        S_READ: begin
          if ({1'b0, k} == ch_eff - 3'd1) begin
            state <= S_DRAIN;
          end else begin
            k <= k + 2'd1;
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_red   <= res[0];
            out_green <= res[1];
            out_blue  <= res[2];
            out_alpha <= res[3];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cap_in_fetch: assert property (@(posedge clk) disable iff (rst)
    cap_valid |-> (state == S_READ || state == S_DRAIN))
    else $error("byte capture outside the fetch phase");

  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> ({1'b0, k} < ch_eff))
    else $error("channel counter beyond channel count");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE))
    else $error("finished result not loaded into output register");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result presented without a finished request");

endmodule
